FILE: src/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Holds the command and result item layouts and the function/op codes.
// No dependencies; tcw_front, tcw_back and text_console_writer_core import it.
`timescale 1ns / 1ps

package tcw_pkg;

    // Field widths fixed by the item layout
    localparam int FUNC_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = CHAR_W + ATTR_W;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Register index (bit 2 of the byte address)
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    // Classified operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ
    } tcw_op_t;

    typedef struct packed {
        tcw_op_t                 op;
        logic [CHAR_W-1:0]       ch;
        logic [CURSOR_ROW_W-1:0] row;
        logic [CURSOR_COL_W-1:0] col;
    } tcw_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0]       cell_char;
        logic [ATTR_W-1:0]       cell_attr;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } tcw_result_t;

endpackage

FILE: src/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/tcw_fifo.sv
// Small generic register queue with push/full and pop/empty sides.
// Used for the command queue and the result queue; no dependencies.
`timescale 1ns / 1ps

module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Store a pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0
                                                               : PtrW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0
                                                               : PtrW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CntW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CntW'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: src/tcw_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on tcw_pkg; feeds the command queue in front of tcw_back.
`timescale 1ns / 1ps

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             push,
    output logic                             full,
    input  logic [tcw_pkg::FUNC_W-1:0]       func,
    input  logic [tcw_pkg::CHAR_W-1:0]       character,
    input  logic [tcw_pkg::CURSOR_ROW_W-1:0] read_row,
    input  logic [tcw_pkg::CURSOR_COL_W-1:0] read_col,
    input  logic                             init_busy,
    input  logic                             q_full,
    output logic                             q_push,
    output tcw_pkg::tcw_cmd_t                q_cmd
);

    import tcw_pkg::*;

    logic in_range;

    // Hold off input while the queue is full or the screen is being initialized
    assign full   = q_full || init_busy;
    assign q_push = push && !full;

    assign in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);

    // Classify the item
    always_comb
    begin
        q_cmd     = '0;
        q_cmd.op  = OP_NONE;
        q_cmd.ch  = character;
        case (func)
            FUNC_PUT:
            begin
                q_cmd.op = (character == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            end
            FUNC_CLEAR:
            begin
                q_cmd.op = OP_CLEAR;
            end
            FUNC_READ:
            begin
                if (in_range)
                begin
                    q_cmd.op  = OP_READ;
                    q_cmd.row = read_row;
                    q_cmd.col = read_col;
                end
            end
            default:
            begin
                q_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

FILE: src/tcw_back.sv
// Back end: owns the cursor and the screen RAM, carries out queued commands
// (put, newline/scroll, clear, read) and pushes one result per command.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]   attr,
    input  tcw_pkg::tcw_cmd_t            cmd_head,
    input  logic                         cmd_empty,
    output logic                         cmd_pop,
    input  logic                         res_full,
    output logic                         res_push,
    output tcw_pkg::tcw_result_t         res,
    output logic                         init_busy
);

    import tcw_pkg::*;

    localparam int Cells   = COLUMNS * ROWS;
    localparam int AddrW   = $clog2(Cells);
    localparam int CntW    = $clog2(Cells + 1);
    localparam int RowW    = $clog2(ROWS);
    localparam int ColW    = $clog2(COLUMNS + 1);
    localparam int Moves   = (ROWS - 1) * COLUMNS;
    localparam int LastRow = ROWS - 1;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_PUT    = 8'b0000_0100,
        S_SCROLL = 8'b0000_1000,
        S_BLANK  = 8'b0001_0000,
        S_CLEAR  = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [RowW-1:0]  row_reg, row_next;
    logic [ColW-1:0]  col_reg, col_next;
    tcw_cmd_t         cmd_reg, cmd_next;
    logic [CntW-1:0]  scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [AddrW-1:0] pend_addr_reg, pend_addr_next;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AddrW-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [CELL_W-1:0] blank_cell;
    logic [AddrW-1:0]  put_addr;
    logic [AddrW-1:0]  rd_addr;
    logic              scan_last;

    assign blank_cell = {attr, BLANK_CHAR};
    assign put_addr   = AddrW'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign rd_addr    = AddrW'(int'(cmd_head.row) * COLUMNS + int'(cmd_head.col));
    assign scan_last  = (scan_reg == CntW'(Cells - 1));
    assign init_busy  = (state_reg == S_INIT);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (Cells)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence the commands
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cmd_next       = cmd_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = rd_addr;
        res            = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AddrW-1:0];
                ram_wdata = {RESET_ATTR, BLANK_CHAR};
                scan_next = CntW'(scan_reg + 1'b1);
                if (scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd_head;
                    scan_next = '0;
                    pend_next = 1'b0;
                    case (cmd_head.op)
                        OP_PUT:
                        begin
                            state_next = S_PUT;
                            if (col_reg >= ColW'(COLUMNS))
                            begin
                                col_next = '0;
                                if (row_reg == RowW'(LastRow))
                                begin
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = RowW'(row_reg + 1'b1);
                                end
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == RowW'(LastRow))
                            begin
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = RowW'(row_reg + 1'b1);
                                state_next = S_RESP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = put_addr;
                ram_wdata  = {attr, cmd_reg.ch};
                col_next   = ColW'(col_reg + 1'b1);
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // Write back the cell read in the previous cycle, one row up
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (scan_reg < CntW'(Moves))
                begin
                    ram_raddr      = AddrW'(int'(scan_reg) + COLUMNS);
                    pend_next      = 1'b1;
                    pend_addr_next = scan_reg[AddrW-1:0];
                    scan_next      = CntW'(scan_reg + 1'b1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AddrW-1:0];
                ram_wdata = blank_cell;
                scan_next = CntW'(scan_reg + 1'b1);
                if (scan_last)
                begin
                    state_next = (cmd_reg.op == OP_PUT) ? S_PUT : S_RESP;
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AddrW-1:0];
                ram_wdata = blank_cell;
                scan_next = CntW'(scan_reg + 1'b1);
                if (scan_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                res_push      = 1'b1;
                res.cell_char = ram_rdata[CHAR_W-1:0];
                res.cell_attr = ram_rdata[CELL_W-1:CHAR_W];
                state_next    = S_IDLE;
            end
            S_RESP:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every result reports the cursor as left by this command
        res.cursor_row = CURSOR_ROW_W'(row_next);
        res.cursor_col = CURSOR_COL_W'(col_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_addr_reg <= pend_addr_next;
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_reg) <= COLUMNS)
        else $error("cursor column beyond line end");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_reg) < ROWS)
        else $error("cursor row beyond last row");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != S_IDLE) && (state_reg != S_INIT))
        else $error("command taken without being carried out");

endmodule

FILE: src/text_console_writer_core.sv
// Text console writer: a COLUMNS x ROWS character screen with a cursor.
// Input channel (push/full): func, character, read_row, read_col. Func put
// writes a byte at the cursor with the current attribute (byte 10 is a
// newline), clear blanks the screen, read returns one cell.
// Result channel (empty/pop): one result per item with cell_char, cell_attr
// (read only, else zero) and the cursor after the item.
// APB port: register text_attribute at byte address 0 (reset 0x0F).
// Flow: items pass a two-entry command queue; the back end carries out one
// item at a time and takes the next only after the last has sent its result.
// Each item and its result pass the command queue, back end and result queue.
// A newline on the last row, or a put that wraps from it, scrolls the screen
// through the single RAM port pair: rows move one up, then the last row blanks.
// A clear blanks all COLUMNS*ROWS cells, then sends its result.
// Reset: the cursor goes to 0,0 and a pass over all COLUMNS*ROWS cells fills
// the screen with blanks of attribute 0x0F; full stays high until it ends.
// Stall: results wait in a two-entry result queue; when it is full the back
// end stops taking commands and full rises once the command queue fills.
`timescale 1ns / 1ps

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             push,
    output logic                             full,
    input  logic [tcw_pkg::FUNC_W-1:0]       func,
    input  logic [tcw_pkg::CHAR_W-1:0]       character,
    input  logic [tcw_pkg::CURSOR_ROW_W-1:0] read_row,
    input  logic [tcw_pkg::CURSOR_COL_W-1:0] read_col,
    // Result channel
    output logic                             empty,
    input  logic                             pop,
    output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]       cell_attr,
    output logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row,
    output logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]      pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    import tcw_pkg::*;

    localparam int QueueDepth = 2;
    localparam int CmdW       = $bits(tcw_cmd_t);
    localparam int ResW       = $bits(tcw_result_t);

    logic [ATTR_W-1:0] attr_reg;
    logic              cfg_write;

    logic              init_busy;
    logic              cq_full;
    logic              cq_push;
    tcw_cmd_t          cq_wcmd;
    logic [CmdW-1:0]   cq_rdata;
    tcw_cmd_t          cq_head;
    logic              cq_empty;
    logic              cq_pop;

    logic              rq_full;
    logic              rq_push;
    tcw_result_t       rq_wres;
    logic [ResW-1:0]   rq_rdata;
    tcw_result_t       rq_head;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (cfg_write && (paddr[2] == REG_TEXT_ATTRIBUTE))
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? PDATA_W'(attr_reg) : '0;

    // Accept and classify
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .push      (push),
        .full      (full),
        .func      (func),
        .character (character),
        .read_row  (read_row),
        .read_col  (read_col),
        .init_busy (init_busy),
        .q_full    (cq_full),
        .q_push    (cq_push),
        .q_cmd     (cq_wcmd)
    );

    // Command queue between front and back
    tcw_fifo #(
        .WIDTH (CmdW),
        .DEPTH (QueueDepth)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wcmd),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    assign cq_head = cq_rdata;

    // Carry out commands
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .cmd_head  (cq_head),
        .cmd_empty (cq_empty),
        .cmd_pop   (cq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res       (rq_wres),
        .init_busy (init_busy)
    );

    // Result queue toward the receiver
    tcw_fifo #(
        .WIDTH (ResW),
        .DEPTH (QueueDepth)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wres),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign rq_head    = rq_rdata;
    assign cell_char  = rq_head.cell_char;
    assign cell_attr  = rq_head.cell_attr;
    assign cursor_row = rq_head.cursor_row;
    assign cursor_col = rq_head.cursor_col;

endmodule
